@@ hdl/tlb_lru_lookup_replace_flush_defines.svh @@
// Assertion macros shared by the TLB modules.
// Expects signals clk and arst_n in the scope of every use.
// Define NO_ASSERTIONS to compile the macros away.
`ifndef TLB_LRU_LOOKUP_REPLACE_FLUSH_DEFINES_SVH
`define TLB_LRU_LOOKUP_REPLACE_FLUSH_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TLB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define TLB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`else

`define TLB_ASSERT_IMP(lbl, ante, cons, msg)
`define TLB_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

@@ hdl/tlb_pkg.sv @@
// Package for the fully associative LRU TLB: request/response beats,
// request codes, controller states and the control/status bundles.
// No dependencies.
package tlb_pkg;

	localparam int TLB_DEPTH   = 16;
	localparam int AGE_SAT_MAX = 255;
	localparam int CFG_W       = 5;
	localparam int ENTRIES_RST = 16;
	localparam int FIELD_W     = 16;

	// request codes
	typedef enum logic [1:0] {
		REQ_LOOKUP  = 2'd0,
		REQ_REPLACE = 2'd1,
		REQ_FLUSH   = 2'd2,
		REQ_NONE    = 2'd3
	} req_code_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [FIELD_W-1:0] pid;
		logic [FIELD_W-1:0] page;
		logic [FIELD_W-1:0] new_frame;
	} tlb_req_t;

	typedef struct packed {
		logic               hit;
		logic [FIELD_W-1:0] frame;
	} tlb_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINAL
	} tlb_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic fin;
	} tlb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic trivial;
		logic scan_done;
	} tlb_sts_t;

endpackage

@@ hdl/tlb_ctrl.sv @@
// Sequencer for the TLB: idle, entry scan and final write/respond.
// Depends on tlb_pkg and the assertion macro header.
`include "tlb_lru_lookup_replace_flush_defines.svh"

module tlb_ctrl
	import tlb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  tlb_sts_t sts,
	output tlb_cmd_t cmd
);

	tlb_state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nx = sts.trivial ? ST_FINAL : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_nx = ST_FINAL;
				end
			end
			ST_FINAL: begin
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy     = 1'b1;
		cmd.load = 1'b0;
		cmd.scan = 1'b0;
		cmd.fin  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_FINAL: begin
				cmd.fin = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	`TLB_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
	`TLB_ASSERT_NXT(a_final_once, state_q == ST_FINAL, state_q == ST_IDLE, "final not one cycle")
	`TLB_ASSERT_NXT(a_scan_end, cmd.scan && sts.scan_done, cmd.fin, "scan end missed final")

endmodule

@@ hdl/tlb_dp.sv @@
// Datapath for the TLB: entry memory with valid bits, scan pipeline,
// match/victim tracking, final write and response register.
// Depends on tlb_pkg and the assertion macro header.
`include "tlb_lru_lookup_replace_flush_defines.svh"

module tlb_dp
	import tlb_pkg::*;
#(
	parameter int DEPTH   = TLB_DEPTH,
	parameter int AGE_MAX = AGE_SAT_MAX
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  tlb_req_t         req,
	input  tlb_cmd_t         cmd,
	output tlb_sts_t         sts,
	output logic             done,
	output tlb_rsp_t         rsp
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int AGE_W = $clog2(AGE_MAX + 1);

	typedef struct packed {
		logic [FIELD_W-1:0] pid;
		logic [FIELD_W-1:0] page;
		logic [FIELD_W-1:0] frame;
		logic [AGE_W-1:0]   age;
	} entry_t;

	entry_t             mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic [CFG_W-1:0]   eiu_q;
	logic [CNT_W-1:0]   n_c;
	tlb_req_t           req_ld;
	tlb_req_t           req_q;
	logic [CNT_W-1:0]   rd_cnt_q;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	entry_t             mem_rd_s1;
	logic               vld_rd_s1;
	logic               proc_s1;
	logic [IDX_W-1:0]   proc_idx_s1;
	entry_t             ent;
	logic               pid_eq;
	logic               page_eq;
	logic [AGE_W-1:0]   age_nx;
	logic               found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [FIELD_W-1:0] hit_frame_q;
	logic [IDX_W-1:0]   victim_q;
	logic [AGE_W-1:0]   best_q;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;
	logic               done_q;
	tlb_rsp_t           rsp_q;

	// active entry count, clamped to depth
	always_comb begin
		if (int'(eiu_q) > DEPTH) begin
			n_c = CNT_W'(DEPTH);
		end else begin
			n_c = CNT_W'(eiu_q);
		end
	end

	assign sts.trivial   = (n_c == '0) || (req.req_type == REQ_NONE);
	assign sts.scan_done = (rd_cnt_q == n_c);

	// entries_in_use register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eiu_q <= CFG_W'(ENTRIES_RST);
		end else if (cfg_we) begin
			eiu_q <= cfg_wdata;
		end
	end

	// request latch; a request with no effect is held as the no-op code
	always_comb begin
		req_ld = req;
		if (sts.trivial) begin
			req_ld.req_type = REQ_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_ld;
		end
	end

	// read side of the scan
	assign rd_en   = cmd.scan && (rd_cnt_q < n_c);
	assign rd_addr = rd_cnt_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			proc_s1  <= 1'b0;
		end else begin
			proc_s1 <= rd_en;
			if (cmd.load) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_s1   <= mem[rd_addr];
			vld_rd_s1   <= vld_q[rd_addr];
			proc_idx_s1 <= rd_addr;
		end
	end

	// entry under test: a never-written entry reads as zero
	always_comb begin
		ent     = vld_rd_s1 ? mem_rd_s1 : '0;
		pid_eq  = (ent.pid == req_q.pid);
		page_eq = (ent.page == req_q.page);
		age_nx  = (ent.age < AGE_W'(AGE_MAX)) ? ent.age + 1'b1 : ent.age;
	end

	// match tracking (last match wins) and victim search (first oldest)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.load) begin
			found_q <= 1'b0;
		end else if (proc_s1 && req_q.req_type == REQ_LOOKUP && pid_eq && page_eq) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1) begin
			if (req_q.req_type == REQ_LOOKUP && pid_eq && page_eq) begin
				hit_idx_q   <= proc_idx_s1;
				hit_frame_q <= ent.frame;
			end
			if (req_q.req_type == REQ_REPLACE &&
				(proc_idx_s1 == '0 || ent.age > best_q)) begin
				best_q   <= ent.age;
				victim_q <= proc_idx_s1;
			end
		end
	end

	// single write port: aged write-back during scan, then the final write
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = proc_idx_s1;
		wr_data = '{pid: ent.pid, page: ent.page, frame: ent.frame, age: age_nx};
		if (proc_s1 && (req_q.req_type == REQ_LOOKUP || req_q.req_type == REQ_REPLACE)) begin
			wr_en = 1'b1;
		end else if (cmd.fin && req_q.req_type == REQ_LOOKUP && found_q) begin
			wr_en   = 1'b1;
			wr_addr = hit_idx_q;
			wr_data = '{pid: req_q.pid, page: req_q.page, frame: hit_frame_q, age: '0};
		end else if (cmd.fin && req_q.req_type == REQ_REPLACE) begin
			wr_en   = 1'b1;
			wr_addr = victim_q;
			wr_data = '{pid: req_q.pid, page: req_q.page, frame: req_q.new_frame, age: '0};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// valid bits: set on write, dropped by flush, all dropped on config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cfg_we) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end else if (proc_s1 && req_q.req_type == REQ_FLUSH && pid_eq) begin
			vld_q[proc_idx_s1] <= 1'b0;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			rsp_q.hit   <= 1'b0;
			rsp_q.frame <= '0;
			if (req_q.req_type == REQ_LOOKUP && found_q && hit_frame_q != '0) begin
				rsp_q.hit   <= 1'b1;
				rsp_q.frame <= hit_frame_q;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`TLB_ASSERT_IMP(a_rw_apart, proc_s1 && rd_en, proc_idx_s1 != rd_addr, "read/write same entry")
	`TLB_ASSERT_IMP(a_cnt_bound, cmd.scan, rd_cnt_q <= n_c, "scan count beyond active entries")
	`TLB_ASSERT_IMP(a_fin_drained, cmd.fin, !proc_s1 && CNT_W'(victim_q) < n_c || !proc_s1 && req_q.req_type != REQ_REPLACE, "final write with scan in flight or bad victim")

endmodule

@@ hdl/tlb_lru_lookup_replace_flush.sv @@
// Top level of the fully associative LRU TLB: controller plus datapath.
// Depends on tlb_pkg, tlb_ctrl and tlb_dp.
//
//  channel   signals                  direction  transfer
//  --------  -----------------------  ---------  -------------------------------
//  config    cfg_we, cfg_wdata        in         cfg_we high at clock edge
//  request   start, busy, req         in         start high and busy low
//  response  done, rsp                out        done high one cycle, no stall
//
// After acceptance a request scans the n active entries in turn (n being
// the active entry count) through the read port of the entry memory,
// drains the read pipeline and then does the final write and response.
// A disabled TLB or the unused code skips the scan. The response appears the
// cycle after the final write; a new request may be taken in that cycle.
// Reset leaves 16 entries active and all entries zero (valid bits cleared).
module tlb_lru_lookup_replace_flush
	import tlb_pkg::*;
#(
	parameter int DEPTH   = TLB_DEPTH,
	parameter int AGE_MAX = AGE_SAT_MAX
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             start,
	output logic             busy,
	input  tlb_req_t         req,
	output logic             done,
	output tlb_rsp_t         rsp
);

	tlb_cmd_t cmd;
	tlb_sts_t sts;

	tlb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	tlb_dp #(
		.DEPTH   (DEPTH),
		.AGE_MAX (AGE_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.rsp       (rsp)
	);

endmodule
